@@ rtl/core/delimited_command_framer_core_macros.svh @@
// Assertion macros shared by the framer modules.
`ifndef DELIMITED_COMMAND_FRAMER_CORE_MACROS_SVH
`define DELIMITED_COMMAND_FRAMER_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define DCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define DCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/dcf_pkg.sv @@
// Types, constants and helper functions for the delimited command framer.
`timescale 1ns / 1ps
package dcf_pkg;

  localparam int BUF_DEPTH_DEF = 32;

  localparam logic [7:0]  CR_BYTE     = 8'h0D;
  localparam logic [31:0] END_SEQ_DEF = 32'h0000_000D;
  localparam logic [2:0]  END_LEN_DEF = 3'd1;
  localparam logic [13:0] TIMEOUT_DEF = 14'd100;
  localparam logic [13:0] TIMEOUT_MIN = 14'd10;
  localparam logic [13:0] TIMEOUT_MAX = 14'd10000;
  localparam logic [13:0] IDLE_MAX    = 14'h3FFF;
  localparam logic [2:0]  SEQ_MAX     = 3'd4;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_WAIT     = 3'd0,
    ST_PROC     = 3'd1,
    ST_OK       = 3'd2,
    ST_NOSTART  = 3'd3,
    ST_BEFORE   = 3'd4,
    ST_TIMEOUT  = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_RECV    = 2'd1,
    PH_READY   = 2'd2,
    PH_TIMEOUT = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    REG_START_SEQ = 3'd0,
    REG_START_LEN = 3'd1,
    REG_END_SEQ   = 3'd2,
    REG_END_LEN   = 3'd3,
    REG_TIMEOUT   = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EXEC,
    CS_SCAN_RD,
    CS_SCAN_CHK,
    CS_EMIT,
    CS_RD_ADDR,
    CS_RD_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_chk;
    logic emit_status;
    logic emit_data;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_t item_cmd;
    logic search_go;
    logic scan_hit;
    logic scan_last;
    logic rd_empty;
    logic rd_last;
    logic out_free;
  } dp_sts_t;

  // Compare the newest n bytes of win against the first n bytes of seq.
  function automatic logic seq_match(input logic [31:0] seq, input logic [31:0] win,
                                     input logic [2:0] n);
    logic        ok;
    logic [2:0]  pos;
    logic [31:0] w;
    ok = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < n) begin
        pos = n - 3'(k) - 3'd1;
        w = win >> {pos[1:0], 3'b000};
        if (seq[8*k +: 8] != w[7:0]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [2:0] clamp_len(input logic [2:0] len);
    return (len > SEQ_MAX) ? SEQ_MAX : len;
  endfunction

endpackage

@@ rtl/core/delimited_command_framer_core.sv @@
// Top level of the delimited command framer.
`timescale 1ns / 1ps
// Input channel (in_valid/in_stall, cmd, rx_byte): one transaction per byte,
// millisecond tick, read or restart. Output channel (out_valid/out_stall):
// status, accepted, data_valid, data_byte, last; each input transaction gives
// one result, a read gives one per command byte with last on the final one.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 start_seq,
// 1 start_len, 2 end_seq, 3 end_len, 4 timeout_ms); the user must write only
// while idle, which the block does not enforce. Byte, tick, restart and an
// empty read pass through EXEC and EMIT; the input opens again in the cycle
// the result appears, so a new transaction waits for the last one's result.
// A byte that completes a command with a start sequence set first scans the
// buffer a byte at a time (SCAN_RD, SCAN_CHK), up to a hit or the end; a
// read streams each byte via the single buffer read port (RD_ADDR, RD_EMIT).
// Reset (rst, synchronous) loads default registers and an empty framer; the
// buffer needs no clearing. While out_stall is high the output register holds
// its result and the sequencer waits; one new input can still be taken and
// worked on up to its own result.
module delimited_command_framer_core #(
  parameter int BUF_DEPTH = dcf_pkg::BUF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        accepted,
  output logic        data_valid,
  output logic [7:0]  data_byte,
  output logic        last
);
  import dcf_pkg::*;

  ctl_cmd_t ctl;
  dp_sts_t  sts;

  dcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  dcf_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_cmd     (cmd),
    .in_byte    (rx_byte),
    .out_stall  (out_stall),
    .ctl        (ctl),
    .sts        (sts),
    .out_valid  (out_valid),
    .status     (status),
    .accepted   (accepted),
    .data_valid (data_valid),
    .data_byte  (data_byte),
    .last       (last)
  );

endmodule

@@ rtl/core/dcf_ctrl.sv @@
// Control state machine sequencing each transaction of the framer.
`timescale 1ns / 1ps
`include "delimited_command_framer_core_macros.svh"
module dcf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dcf_pkg::dp_sts_t  sts,
  output dcf_pkg::ctl_cmd_t ctl
);
  import dcf_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (in_valid) state_next = CS_EXEC;
      end
      CS_EXEC: begin
        case (sts.item_cmd)
          CMD_READ: state_next = sts.rd_empty ? CS_EMIT : CS_RD_ADDR;
          CMD_BYTE: state_next = sts.search_go ? CS_SCAN_RD : CS_EMIT;
          default:  state_next = CS_EMIT;
        endcase
      end
      CS_SCAN_RD: state_next = CS_SCAN_CHK;
      CS_SCAN_CHK: begin
        if (sts.scan_hit || sts.scan_last) state_next = CS_EMIT;
        else state_next = CS_SCAN_RD;
      end
      CS_EMIT: begin
        if (sts.out_free) state_next = CS_IDLE;
      end
      CS_RD_ADDR: state_next = CS_RD_EMIT;
      CS_RD_EMIT: begin
        if (sts.out_free) state_next = sts.rd_last ? CS_IDLE : CS_RD_ADDR;
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    case (state)
      CS_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid;
      end
      CS_EXEC:     ctl.exec = 1'b1;
      CS_SCAN_CHK: ctl.scan_chk = 1'b1;
      CS_EMIT:     ctl.emit_status = sts.out_free;
      CS_RD_EMIT:  ctl.emit_data = sts.out_free;
      default: begin
        ctl      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

  `DCF_ASSERT_NEXT(a_load_exec, ctl.load, state == CS_EXEC, "load not followed by execute")
  `DCF_ASSERT_NOW(a_one_emit, 1'b1, !(ctl.emit_status && ctl.emit_data), "two results at once")
  `DCF_ASSERT_NOW(a_stall_busy, state != CS_IDLE, in_stall, "input open while busy")

endmodule

@@ rtl/core/dcf_datapath.sv @@
// Datapath: configuration, command buffer, framing state and output register.
`timescale 1ns / 1ps
`include "delimited_command_framer_core_macros.svh"
module dcf_datapath #(
  parameter int BUF_DEPTH = dcf_pkg::BUF_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [1:0]        in_cmd,
  input  logic [7:0]        in_byte,
  input  logic              out_stall,
  input  dcf_pkg::ctl_cmd_t ctl,
  output dcf_pkg::dp_sts_t  sts,
  output logic              out_valid,
  output logic [2:0]        status,
  output logic              accepted,
  output logic              data_valid,
  output logic [7:0]        data_byte,
  output logic              last
);
  import dcf_pkg::*;

  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int AW = $clog2(BUF_DEPTH);

  logic [31:0] start_seq;
  logic [2:0]  start_len;
  logic [31:0] end_seq;
  logic [2:0]  end_len;
  logic [13:0] timeout_ms;

  logic [7:0]  mem [BUF_DEPTH];
  logic [7:0]  rdata;

  cmd_t        item_cmd;
  logic [7:0]  item_byte;
  logic        acc_flag;

  phase_t      phase;
  status_t     status_reg;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] payload_start;
  logic [CW-1:0] idx;
  logic [13:0] idle_ms;
  logic        timer_armed;
  logic [31:0] tail_bytes;
  logic [31:0] window;

  logic [2:0]  end_n;
  logic [31:0] end_s;
  logic [2:0]  start_n;
  logic        refused;
  logic [CW-1:0] base_fill;
  logic [31:0] base_tail;
  status_t     base_status;
  logic        byte_wr;
  logic [CW-1:0] fill_new;
  logic [31:0] tail_new;
  status_t     status_new;
  logic        end_hit;
  logic [CW-1:0] cmd_len;
  logic [13:0] idle_inc;
  logic [31:0] win_new;
  logic [CW-1:0] idx_inc;
  logic        scan_hit;
  logic        rd_last;
  logic        mem_we;
  logic        do_restart;
  logic        emit;
  logic [13:0] t_wr;

  always_comb begin
    end_n   = (end_len == 3'd0) ? 3'd1 : clamp_len(end_len);
    end_s   = (end_len == 3'd0) ? {24'd0, CR_BYTE} : end_seq;
    start_n = clamp_len(start_len);
    refused = (phase == PH_READY) || (phase == PH_TIMEOUT);

    base_fill   = (phase == PH_WAIT) ? '0 : fill_count;
    base_tail   = (phase == PH_WAIT) ? '0 : tail_bytes;
    base_status = (phase == PH_WAIT) ? ST_PROC : status_reg;
    byte_wr     = base_fill < CW'(BUF_DEPTH);
    fill_new    = base_fill + CW'(byte_wr);
    tail_new    = {base_tail[23:0], item_byte};
    status_new  = byte_wr ? base_status : ST_OVERFLOW;
    end_hit     = (fill_new >= CW'(end_n)) && seq_match(end_s, tail_new, end_n);
    cmd_len     = fill_new - CW'(end_n);

    idle_inc = (idle_ms < IDLE_MAX) ? idle_ms + 14'd1 : idle_ms;

    win_new  = {window[23:0], rdata};
    idx_inc  = idx + CW'(1);
    scan_hit = (idx_inc >= CW'(start_n)) && seq_match(start_seq, win_new, start_n);
    rd_last  = idx_inc == fill_count;

    mem_we = ctl.exec && (item_cmd == CMD_BYTE) && !refused && byte_wr;
    emit   = ctl.emit_status || ctl.emit_data;
    do_restart = (cfg_we && (cfg_index == REG_TIMEOUT))
              || (ctl.exec && (item_cmd == CMD_RESTART))
              || (ctl.emit_status && (item_cmd == CMD_READ))
              || (ctl.emit_data && rd_last);
    t_wr = cfg_data[13:0];

    sts.item_cmd  = item_cmd;
    sts.search_go = !refused && end_hit && (status_new != ST_OVERFLOW)
                 && (start_n != 3'd0) && (cmd_len >= CW'(start_n));
    sts.scan_hit  = scan_hit;
    sts.scan_last = idx_inc >= fill_count;
    sts.rd_empty  = payload_start >= fill_count;
    sts.rd_last   = rd_last;
    sts.out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_seq  <= '0;
      start_len  <= '0;
      end_seq    <= END_SEQ_DEF;
      end_len    <= END_LEN_DEF;
      timeout_ms <= TIMEOUT_DEF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_SEQ: start_seq <= cfg_data;
        REG_START_LEN: start_len <= cfg_data[2:0];
        REG_END_SEQ:   end_seq <= cfg_data;
        REG_END_LEN:   end_len <= cfg_data[2:0];
        REG_TIMEOUT: begin
          timeout_ms <= (t_wr >= TIMEOUT_MIN && t_wr <= TIMEOUT_MAX) ? t_wr : TIMEOUT_DEF;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || do_restart) begin
      phase         <= PH_WAIT;
      status_reg    <= ST_WAIT;
      fill_count    <= '0;
      payload_start <= '0;
      idle_ms       <= '0;
      timer_armed   <= 1'b0;
      tail_bytes    <= '0;
    end else if (ctl.exec) begin
      case (item_cmd)
        CMD_BYTE: begin
          if (!refused) begin
            timer_armed <= 1'b1;
            idle_ms     <= '0;
            tail_bytes  <= tail_new;
            fill_count  <= fill_new;
            status_reg  <= status_new;
            phase       <= end_hit ? PH_READY : PH_RECV;
            if (end_hit && (status_new != ST_OVERFLOW)) begin
              fill_count    <= cmd_len;
              payload_start <= '0;
              status_reg    <= (start_n == 3'd0) ? ST_OK : ST_NOSTART;
            end
          end
        end
        CMD_TICK: begin
          if (phase == PH_RECV && timer_armed) begin
            idle_ms <= idle_inc;
            if (idle_inc > timeout_ms) begin
              phase      <= PH_TIMEOUT;
              status_reg <= ST_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end else if (ctl.scan_chk && scan_hit) begin
      payload_start <= idx_inc;
      status_reg    <= (idx_inc == CW'(start_n)) ? ST_OK : ST_BEFORE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_cmd  <= cmd_t'(in_cmd);
      item_byte <= in_byte;
    end
    if (ctl.exec) begin
      acc_flag <= (item_cmd == CMD_BYTE) && !refused;
      idx      <= (item_cmd == CMD_READ) ? payload_start : '0;
      window   <= '0;
    end else if (ctl.scan_chk) begin
      window <= win_new;
      idx    <= idx_inc;
    end else if (ctl.emit_data && !rd_last) begin
      idx <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[base_fill[AW-1:0]] <= item_byte;
    rdata <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_status) begin
      status     <= status_reg;
      accepted   <= acc_flag;
      data_valid <= 1'b0;
      data_byte  <= '0;
      last       <= 1'b1;
    end else if (ctl.emit_data) begin
      status     <= status_reg;
      accepted   <= 1'b0;
      data_valid <= 1'b1;
      data_byte  <= rdata;
      last       <= rd_last;
    end
  end

  `DCF_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= CW'(BUF_DEPTH), "fill count past depth")
  `DCF_ASSERT_NOW(a_start_bound, 1'b1, payload_start <= fill_count, "payload start past fill")
  `DCF_ASSERT_NOW(a_emit_free, emit, !out_valid || !out_stall, "result over a held one")
  `DCF_ASSERT_NEXT(a_rd_status, ctl.emit_data && !rd_last, status_reg == $past(status_reg),
                   "status moved during read-out")

endmodule

@@ bench/delimited_command_framer_core_tb.sv @@
// Self-checking testbench for the delimited command framer core.
`timescale 1ns / 1ps
module delimited_command_framer_core_tb;
  import dcf_pkg::*;

  localparam int BUF_DEPTH    = BUF_DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int ITEM_GOAL    = 130;
  localparam int HOLD_CYCLES  = 150;
  localparam logic [2:0] REG_SPARE = 3'd7;

  typedef struct packed {
    status_t    status;
    logic       accepted;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       last;
  } framer_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = '0;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        accepted;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic        last;

  // framer shadow: registers and state
  logic [31:0] reg_start_seq, reg_end_seq;
  logic [2:0]  reg_start_len, reg_end_len;
  logic [13:0] reg_timeout;
  logic [7:0]  held_bytes [BUF_DEPTH];
  int          held_count, held_from, idle_ms;
  phase_t      fr_phase;
  status_t     fr_status;
  bit          armed;
  logic [31:0] tail;

  framer_out_t due_outputs[$];
  int          mismatches = 0;
  int          item_count = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  bit          hold_go = 1'b0;
  bit          gaps_on = 1'b1;

  delimited_command_framer_core #(.BUF_DEPTH(BUF_DEPTH)) i_dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom());
  endfunction

  function automatic int eff_end_len();
    return (reg_end_len == 0) ? 1
         : ((reg_end_len > SEQ_MAX) ? int'(SEQ_MAX) : int'(reg_end_len));
  endfunction

  function automatic logic [31:0] eff_end_seq();
    return (reg_end_len == 0) ? {24'd0, CR_BYTE} : reg_end_seq;
  endfunction

  function automatic int eff_start_len();
    return (reg_start_len > SEQ_MAX) ? int'(SEQ_MAX) : int'(reg_start_len);
  endfunction

  function automatic void framer_restart();
    fr_phase   = PH_WAIT;
    fr_status  = ST_WAIT;
    held_count = 0;
    held_from  = 0;
    idle_ms    = 0;
    armed      = 1'b0;
    tail       = '0;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] d);
    case (idx)
      REG_START_SEQ: reg_start_seq = d;
      REG_START_LEN: reg_start_len = d[2:0];
      REG_END_SEQ:   reg_end_seq = d;
      REG_END_LEN:   reg_end_len = d[2:0];
      REG_TIMEOUT: begin
        reg_timeout = (d[13:0] >= TIMEOUT_MIN && d[13:0] <= TIMEOUT_MAX) ? d[13:0] : TIMEOUT_DEF;
        framer_restart();
      end
      default: ;
    endcase
  endfunction

  function automatic void push_out(status_t s, logic acc, logic dv, logic [7:0] d, logic lst);
    framer_out_t r;
    r.status     = s;
    r.accepted   = acc;
    r.data_valid = dv;
    r.data_byte  = d;
    r.last       = lst;
    due_outputs.push_back(r);
  endfunction

  // strip the end sequence, then search for the start sequence
  function automatic void close_command(int n);
    int sl, len;
    bit hit;
    sl = eff_start_len();
    len = held_count - n;
    held_count = len;
    held_from = 0;
    fr_status = ST_OK;
    if (sl == 0) return;
    fr_status = ST_NOSTART;
    for (int p = 0; p + sl <= len; p++) begin
      hit = 1'b1;
      for (int k = 0; k < sl; k++)
        if (held_bytes[p + k] != reg_start_seq[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        held_from = p + sl;
        fr_status = (p != 0) ? ST_BEFORE : ST_OK;
        return;
      end
    end
  endfunction

  function automatic void take_byte(logic [7:0] b);
    int n;
    logic [31:0] seq;
    bit seen;
    n = eff_end_len();
    seq = eff_end_seq();
    if (fr_phase == PH_WAIT) begin
      framer_restart();
      fr_phase = PH_RECV;
      fr_status = ST_PROC;
    end
    armed = 1'b1;
    idle_ms = 0;
    tail = {tail[23:0], b};
    if (held_count < BUF_DEPTH) begin
      held_bytes[held_count] = b;
      held_count++;
    end else begin
      fr_status = ST_OVERFLOW;
    end
    seen = (held_count >= n);
    for (int k = 0; k < n; k++)
      if (seq[8*k +: 8] != tail[8*(n-1-k) +: 8]) seen = 1'b0;
    if (seen) begin
      fr_phase = PH_READY;
      if (fr_status != ST_OVERFLOW) close_command(n);
    end
  endfunction

  function automatic void advance_framer(cmd_t c, logic [7:0] b);
    status_t st_before;
    int top;
    case (c)
      CMD_BYTE: begin
        if (fr_phase == PH_READY || fr_phase == PH_TIMEOUT) begin
          push_out(fr_status, 1'b0, 1'b0, 8'h00, 1'b1);
        end else begin
          take_byte(b);
          push_out(fr_status, 1'b1, 1'b0, 8'h00, 1'b1);
        end
      end
      CMD_TICK: begin
        if (fr_phase == PH_RECV && armed) begin
          if (idle_ms < IDLE_MAX) idle_ms++;
          if (idle_ms > reg_timeout) begin
            fr_phase = PH_TIMEOUT;
            fr_status = ST_TIMEOUT;
          end
        end
        push_out(fr_status, 1'b0, 1'b0, 8'h00, 1'b1);
      end
      CMD_READ: begin
        st_before = fr_status;
        top = held_count;
        for (int i = held_from; i < top; i++)
          push_out(st_before, 1'b0, 1'b1, held_bytes[i], i + 1 == top);
        if (held_from >= top) push_out(st_before, 1'b0, 1'b0, 8'h00, 1'b1);
        framer_restart();
      end
      CMD_RESTART: begin
        framer_restart();
        push_out(fr_status, 1'b0, 1'b0, 8'h00, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    framer_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_outputs.size() == 0) begin
          $error("unexpected result: status %0d data_byte %0h", status, data_byte);
          mismatches++;
        end else begin
          want = due_outputs.pop_front();
          check_field("status", 8'(want.status), 8'(status));
          check_field("accepted", 8'(want.accepted), 8'(accepted));
          check_field("data_valid", 8'(want.data_valid), 8'(data_valid));
          check_field("data_byte", want.data_byte, data_byte);
          check_field("last", 8'(want.last), 8'(last));
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < 25);
      end
    end
  end

  task automatic send_item(cmd_t c, logic [7:0] b);
    while (gaps_on && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item_count++;
    advance_framer(c, b);
  endtask

  task automatic send_seq(logic [31:0] seq, int n);
    for (int k = 0; k < n; k++) send_item(CMD_BYTE, seq[8*k +: 8]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    apply_reg(idx, d);
  endtask

  task automatic program_regs(logic [31:0] ss, logic [31:0] sl, logic [31:0] es,
                              logic [31:0] el, logic [31:0] tmo);
    write_reg(REG_START_SEQ, ss);
    write_reg(REG_START_LEN, sl);
    write_reg(REG_END_SEQ, es);
    write_reg(REG_END_LEN, el);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_SPARE, $urandom());
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] len_word(int len);
    logic [31:0] w;
    w = $urandom();
    w[2:0] = 3'(len);
    return w;
  endfunction

  function automatic logic [31:0] tmo_word(int t);
    logic [31:0] w;
    w = $urandom();
    w[13:0] = 14'(t);
    return w;
  endfunction

  task automatic test_plain_frames();
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_READ, 8'hFF);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_RESTART, 8'h00);
    send_item(CMD_BYTE, 8'h5A);
    send_item(CMD_READ, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, CR_BYTE);
    send_item(CMD_BYTE, 8'h41);
    send_item(CMD_READ, 8'h00);
    wait_drained();
  endtask

  task automatic test_start_outcomes();
    program_regs(32'h5A5A_6261, len_word(2), $urandom(), len_word(0),
                 tmo_word(int'(TIMEOUT_MAX)));
    send_item(CMD_BYTE, 8'h78);
    send_seq(reg_start_seq, 2);
    send_item(CMD_BYTE, 8'h6B);
    send_item(CMD_BYTE, CR_BYTE);
    send_item(CMD_READ, 8'h00);
    send_seq(reg_start_seq, 2);
    send_item(CMD_BYTE, CR_BYTE);
    send_item(CMD_READ, 8'h00);
    send_item(CMD_BYTE, 8'h71);
    send_item(CMD_BYTE, CR_BYTE);
    send_item(CMD_READ, 8'h00);
    wait_drained();
  endtask

  task automatic test_long_delimiters();
    program_regs($urandom(), len_word(7), $urandom(), len_word(7),
                 tmo_word(int'(TIMEOUT_MIN) - 1));
    send_seq(reg_start_seq, 4);
    send_item(CMD_BYTE, rand_byte());
    send_seq(reg_end_seq, 4);
    send_item(CMD_READ, 8'h00);
    wait_drained();
  endtask

  task automatic random_command(int kind);
    case (kind)
      0, 1, 2, 3, 4, 5: begin
        if (eff_start_len() > 0 && $urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) send_item(CMD_BYTE, rand_byte());
        if ($urandom_range(0, 5) != 0) send_seq(reg_start_seq, eff_start_len());
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0) send_item(CMD_TICK, rand_byte());
          send_item(CMD_BYTE, rand_byte());
        end
        send_seq(eff_end_seq(), eff_end_len());
        if ($urandom_range(0, 2) == 0) send_item(CMD_BYTE, rand_byte());
        send_item(CMD_READ, rand_byte());
      end
      6: begin
        repeat ($urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 6)) send_item(CMD_BYTE, rand_byte());
        send_seq(eff_end_seq(), eff_end_len());
        send_item(CMD_READ, rand_byte());
      end
      7: begin
        repeat ($urandom_range(1, 3)) send_item(CMD_BYTE, rand_byte());
        repeat ((reg_timeout <= 14) ? reg_timeout + 1 : 12) send_item(CMD_TICK, rand_byte());
        send_item(CMD_BYTE, rand_byte());
        send_item(CMD_READ, rand_byte());
      end
      8: begin
        repeat ($urandom_range(1, 4)) send_item(cmd_t'($urandom_range(0, 3)), rand_byte());
      end
      default: begin
        repeat ($urandom_range(1, 3)) send_item(CMD_BYTE, rand_byte());
        if ($urandom_range(0, 1) == 0) send_item(CMD_RESTART, rand_byte());
        else send_item(CMD_READ, rand_byte());
      end
    endcase
  endtask

  task automatic test_random_traffic();
    int round, tmo;
    round = 0;
    while (item_count < ITEM_GOAL || round < 2) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       tmo = $urandom_range(0, 16383);
        1:       tmo = int'(TIMEOUT_MIN) - 1;
        2:       tmo = int'(TIMEOUT_MAX) + 1;
        3:       tmo = int'(TIMEOUT_MAX);
        default: tmo = $urandom_range(10, 14);
      endcase
      if (round == 1) tmo = int'(TIMEOUT_MIN);
      program_regs($urandom(), len_word($urandom_range(0, 7)), $urandom(),
                   len_word($urandom_range(0, 7)), tmo_word(tmo));
      gaps_on = (round != 1);
      if (round == 0) hold_go = 1'b1;
      if (round == 0) random_command(6);
      if (round == 1) random_command(7);
      repeat ($urandom_range(1, 3)) random_command($urandom_range(0, 9));
      round++;
    end
    wait_drained();
    gaps_on = 1'b1;
  endtask

  initial begin
    reg_start_seq = '0;
    reg_start_len = '0;
    reg_end_seq   = END_SEQ_DEF;
    reg_end_len   = END_LEN_DEF;
    reg_timeout   = TIMEOUT_DEF;
    framer_restart();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_frames();
    test_start_outcomes();
    test_long_delimiters();
    test_random_traffic();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_outputs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
